[rtl/core/lzwd_pkg.sv]
// ----------------------------------------------------------------------------
// lzwd_pkg: shared definitions for the LZ77 window decoder
// Holds the default window size, the command format passed from the parser
// to the copy engine, and the result status codes.
// ----------------------------------------------------------------------------
package lzwd_pkg;

	localparam int unsigned WINDOW_BYTES_DEF = 4096;

	// Depth of the command queue between parser and copy engine.
	localparam int unsigned CMD_DEPTH = 4;
	localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);

	localparam int unsigned LEN_W    = 7;
	localparam int unsigned OFFSET_W = 16;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_OFFSET = 2'd1,
		STATUS_TRUNC  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_LIT  = 2'd0,
		CMD_COPY = 2'd1,
		CMD_ERR  = 2'd2
	} cmd_kind_t;

	// One unit of work for the copy engine.
	typedef struct packed {
		cmd_kind_t             kind;
		logic [7:0]            data;
		logic [LEN_W-1:0]      len;
		logic [OFFSET_W-1:0]   offset;
		status_t               status;
	} cmd_t;

endpackage

[rtl/core/lzwd_in_if.sv]
// ----------------------------------------------------------------------------
// lzwd_in_if: compressed byte channel
// Valid/ready channel carrying one byte of the compressed stream per
// transaction, with an end-of-stream flag.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       end_of_stream;

	modport source (output valid, output stream_byte, output end_of_stream, input ready);
	modport sink (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

[rtl/core/lzwd_out_if.sv]
// ----------------------------------------------------------------------------
// lzwd_out_if: decoded result channel
// Valid/ready channel carrying up to two decoded bytes, a status code and
// an end-of-run flag per transaction.
// ----------------------------------------------------------------------------
interface lzwd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic [1:0] byte_count;
	logic [1:0] status;
	logic       last_of_run;

	modport source (output valid, output first_byte, output second_byte, output byte_count,
		output status, output last_of_run, input ready);
	modport sink (input valid, input first_byte, input second_byte, input byte_count,
		input status, input last_of_run, output ready);
endinterface

[rtl/core/lzwd_front.sv]
// ----------------------------------------------------------------------------
// lzwd_front: token parser
// Accepts compressed bytes, assembles match tokens and offsets, checks
// offsets against its own copy of the window fill, and issues literal,
// copy and error commands to the queue.
// ----------------------------------------------------------------------------
module lzwd_front
	import lzwd_pkg::*;
#(
	parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lzwd_in_if.sink      stream,
	output logic         push,
	output cmd_t         push_cmd,
	input  logic         fifo_full
);

	localparam int unsigned FW = $clog2(WINDOW_BYTES + 1);

	typedef enum logic [3:0] {
		PH_TOKEN  = 4'b0001,
		PH_OFF_LO = 4'b0010,
		PH_OFF_HI = 4'b0100,
		PH_HALT   = 4'b1000
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [7:0]          off_lo_q, off_lo_d;
	logic [FW-1:0]       fill_q, fill_d;

	logic                accept;
	logic [OFFSET_W-1:0] offset;
	logic                offset_bad;
	logic [LEN_W-1:0]    add_amt;
	logic [FW:0]         fill_sum;
	logic [FW-1:0]       fill_next;

	// A halted parser keeps draining the input and drops every byte.
	assign stream.ready = (phase_q == PH_HALT) || !fifo_full;
	assign accept       = stream.valid && stream.ready;

	assign offset     = {stream.stream_byte, off_lo_q};
	assign offset_bad = {1'b0, offset} > (OFFSET_W + 1)'(fill_q);

	// The fill grows by one for a literal and by the length for a copy.
	assign add_amt   = (phase_q == PH_OFF_HI) ? len_q : LEN_W'(1);
	assign fill_sum  = {1'b0, fill_q} + (FW + 1)'(add_amt);
	assign fill_next = (fill_sum > (FW + 1)'(WINDOW_BYTES)) ? FW'(WINDOW_BYTES)
		: fill_sum[FW-1:0];

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		off_lo_d = off_lo_q;
		fill_d   = fill_q;
		push     = 1'b0;
		push_cmd = '0;
		if (accept) begin
			case (phase_q)
				PH_OFF_LO: begin
					if (stream.end_of_stream) begin
						push            = 1'b1;
						push_cmd.kind   = CMD_ERR;
						push_cmd.status = STATUS_TRUNC;
						phase_d         = PH_HALT;
					end else begin
						off_lo_d = stream.stream_byte;
						phase_d  = PH_OFF_HI;
					end
				end
				PH_OFF_HI: begin
					phase_d = PH_TOKEN;
					if (offset_bad) begin
						push            = 1'b1;
						push_cmd.kind   = CMD_ERR;
						push_cmd.status = STATUS_OFFSET;
						phase_d         = PH_HALT;
					end else if (len_q != '0) begin
						push            = 1'b1;
						push_cmd.kind   = CMD_COPY;
						push_cmd.len    = len_q;
						push_cmd.offset = offset;
						fill_d          = fill_next;
					end
				end
				PH_HALT: begin
				end
				default: begin
					phase_d = PH_TOKEN;
					if (!stream.stream_byte[7]) begin
						push          = 1'b1;
						push_cmd.kind = CMD_LIT;
						push_cmd.data = stream.stream_byte;
						fill_d        = fill_next;
					end else if (stream.end_of_stream) begin
						push            = 1'b1;
						push_cmd.kind   = CMD_ERR;
						push_cmd.status = STATUS_TRUNC;
						phase_d         = PH_HALT;
					end else begin
						len_d   = stream.stream_byte[LEN_W-1:0];
						phase_d = PH_OFF_LO;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TOKEN;
			len_q    <= '0;
			off_lo_q <= '0;
			fill_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			off_lo_q <= off_lo_d;
			fill_q   <= fill_d;
		end
	end

endmodule

[rtl/core/lzwd_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// lzwd_cmd_fifo: command queue
// Small register queue that decouples the parser from the copy engine.
// ----------------------------------------------------------------------------
module lzwd_cmd_fifo
	import lzwd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	cmd_t                 slots_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == (CMD_PTR_W + 1)'(CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/lzwd_back.sv]
// ----------------------------------------------------------------------------
// lzwd_back: copy engine
// Executes queued commands against the history memory, packs copied
// bytes in pairs and holds each result in an output register.
// ----------------------------------------------------------------------------
module lzwd_back
	import lzwd_pkg::*;
#(
	parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	input  logic         cmd_empty,
	output logic         pop,
	lzwd_out_if.source   decoded
);

	localparam int unsigned AW = $clog2(WINDOW_BYTES);
	localparam int unsigned FW = $clog2(WINDOW_BYTES + 1);
	localparam int unsigned SW = AW + 2;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'b001,
		BK_READ  = 3'b010,
		BK_WRITE = 3'b100
	} bk_state_t;

	logic [7:0] hist_mem [WINDOW_BYTES];

	bk_state_t        st_q, st_d;
	logic [AW-1:0]    wp_q;
	logic [FW-1:0]    fill_q;
	logic [AW-1:0]    src_q, src_d;
	logic [LEN_W-1:0] remain_q, remain_d;
	logic [7:0]       held_q, held_d;
	logic             have_q, have_d;
	logic             zero_q;
	logic [7:0]       rd_data_q;

	logic             out_valid_q;
	logic [7:0]       out_first_q, out_second_q;
	logic [1:0]       out_count_q;
	status_t          out_status_q;
	logic             out_last_q;

	logic             out_free;
	logic             rd_en;
	logic             wr_en;
	logic [7:0]       wr_data;
	logic             emit;
	logic [7:0]       e_first, e_second;
	logic [1:0]       e_count;
	status_t          e_status;
	logic             e_last;
	logic [7:0]       copy_byte;
	logic             last_byte;
	logic [SW-1:0]    src_base;
	logic [AW-1:0]    src_start;
	logic [AW-1:0]    src_inc;
	logic             unwritten;

	assign out_free  = !out_valid_q || decoded.ready;
	assign copy_byte = zero_q ? 8'd0 : rd_data_q;
	assign last_byte = (remain_q == LEN_W'(1));

	// Copy source: offset bytes behind the write position, modulo the window.
	assign src_base = SW'(wp_q) + SW'(WINDOW_BYTES) - SW'(cmd.offset[FW-1:0]);
	assign src_start = (src_base >= SW'(WINDOW_BYTES)) ? AW'(src_base - SW'(WINDOW_BYTES))
		: src_base[AW-1:0];
	assign src_inc = (src_q == AW'(WINDOW_BYTES - 1)) ? '0 : src_q + 1'b1;

	// Slots at or above the fill have never been written and read as zero.
	assign unwritten = (fill_q != FW'(WINDOW_BYTES)) && (FW'(src_q) >= fill_q);

	always_comb begin
		st_d     = st_q;
		src_d    = src_q;
		remain_d = remain_q;
		held_d   = held_q;
		have_d   = have_q;
		pop      = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_data  = copy_byte;
		emit     = 1'b0;
		e_first  = '0;
		e_second = '0;
		e_count  = '0;
		e_status = STATUS_OK;
		e_last   = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (!cmd_empty && out_free) begin
					pop = 1'b1;
					case (cmd.kind)
						CMD_LIT: begin
							wr_en   = 1'b1;
							wr_data = cmd.data;
							emit    = 1'b1;
							e_first = cmd.data;
							e_count = 2'd1;
							e_last  = 1'b1;
						end
						CMD_COPY: begin
							src_d    = src_start;
							remain_d = cmd.len;
							have_d   = 1'b0;
							st_d     = BK_READ;
						end
						default: begin
							emit     = 1'b1;
							e_status = cmd.status;
							e_last   = 1'b1;
						end
					endcase
				end
			end
			BK_READ: begin
				rd_en = 1'b1;
				st_d  = BK_WRITE;
			end
			BK_WRITE: begin
				if (have_q || last_byte) begin
					if (out_free) begin
						wr_en  = 1'b1;
						emit   = 1'b1;
						e_last = last_byte;
						have_d = 1'b0;
						if (have_q) begin
							e_first  = held_q;
							e_second = copy_byte;
							e_count  = 2'd2;
						end else begin
							e_first = copy_byte;
							e_count = 2'd1;
						end
					end
				end else begin
					wr_en  = 1'b1;
					have_d = 1'b1;
					held_d = copy_byte;
				end
				if (wr_en) begin
					src_d    = src_inc;
					remain_d = remain_q - 1'b1;
					st_d     = last_byte ? BK_IDLE : BK_READ;
				end
			end
			default: begin
				st_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[wp_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= hist_mem[src_q];
			zero_q    <= unwritten;
		end
	end

	always_ff @(posedge clk) begin
		src_q    <= src_d;
		remain_q <= remain_d;
		held_q   <= held_d;
		if (emit) begin
			out_first_q  <= e_first;
			out_second_q <= e_second;
			out_count_q  <= e_count;
			out_status_q <= e_status;
			out_last_q   <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			have_q <= have_d;
			if (wr_en) begin
				wp_q <= (wp_q == AW'(WINDOW_BYTES - 1)) ? '0 : wp_q + 1'b1;
				if (fill_q != FW'(WINDOW_BYTES)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (decoded.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign decoded.valid       = out_valid_q;
	assign decoded.first_byte  = out_first_q;
	assign decoded.second_byte = out_second_q;
	assign decoded.byte_count  = out_count_q;
	assign decoded.status      = out_status_q;
	assign decoded.last_of_run = out_last_q;

endmodule

[rtl/core/lz77_window_decoder.sv]
// ----------------------------------------------------------------------------
// lz77_window_decoder: streaming LZ77 decoder with a sliding history window
// Parser, command queue and copy engine around a WINDOW_BYTES history
// memory; decoded bytes leave up to two at a time.
// ----------------------------------------------------------------------------
// The decoder takes one compressed byte per transaction on the stream
// channel and returns decoded bytes, up to two per transaction, on the
// decoded channel. A parser accepts a byte every cycle while its
// four-entry command queue has room. The copy engine writes a literal
// straight into the history memory and the output register; for every
// byte of a match it first reads the history memory (BK_READ) and then
// writes the copied byte back and packs it (BK_WRITE), because each
// copied byte may be the source of the next one in an overlapping copy.
// The engine takes no new command until a match is done. While the
// consumer is ready, literal results can leave every cycle and a match
// delivers its bytes in pairs, the last one alone if the length is odd.
// The history memory has no clearing pass after reset: a count of filled
// slots makes a read of a never-written slot return zero. After an offset
// or truncation error the block reports one status transaction and then
// drains and drops all input until the next reset.
// ----------------------------------------------------------------------------
module lz77_window_decoder
	import lzwd_pkg::*;
#(
	parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lzwd_in_if.sink    stream,
	lzwd_out_if.source decoded
);

	// Commands flow from the parser into the queue and out to the engine.
	logic push;
	cmd_t push_cmd;
	logic fifo_full;
	logic pop;
	cmd_t pop_cmd;
	logic fifo_empty;

	lzwd_front #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.push      (push),
		.push_cmd  (push_cmd),
		.fifo_full (fifo_full)
	);

	lzwd_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (fifo_empty)
	);

	// The engine owns the history memory and the output register.
	lzwd_back #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pop_cmd),
		.cmd_empty (fifo_empty),
		.pop       (pop),
		.decoded   (decoded)
	);

endmodule
